@@ sv/mbce_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbce_pkg
// Shared types, constants and helpers of the monochrome colour expansion
// blitter: request and result layouts, register map and colour packing.
// ----------------------------------------------------------------------------
package mbce_pkg;

  // largest bitmap side in pixels, wider requests saturate here
  localparam logic [12:0] MAX_DIM = 13'd4096;

  // request kinds
  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  // register map of the configuration port
  typedef enum logic [2:0] {
    REG_BASE_ADDRESS    = 3'd0,
    REG_SCREEN_WIDTH    = 3'd1,
    REG_SCREEN_HEIGHT   = 3'd2,
    REG_ROW_PITCH       = 3'd3,
    REG_BYTES_PER_PIXEL = 3'd4,
    REG_RED_FORMAT      = 3'd5,
    REG_GREEN_FORMAT    = 3'd6,
    REG_BLUE_FORMAT     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic        operation;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [12:0] glyph_width;
    logic [12:0] glyph_height;
    logic [9:0]  glyph_stride;
    logic        msb_first;
    logic [23:0] fore_rgb;
    logic [23:0] back_rgb;
    logic [7:0]  bitmap_byte;
  } item_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [31:0] pixel_value;
    logic [2:0]  byte_count;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [31:0] base_address;
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [15:0] row_pitch;
    logic [2:0]  bytes_per_pixel;
    logic [8:0]  red_format;
    logic [8:0]  green_format;
    logic [8:0]  blue_format;
  } cfg_t;

  // one bitmap byte's worth of pixel writes, handed from front to back
  typedef struct packed {
    logic [28:0] row_part;
    logic [15:0] col_part;
    logic [3:0]  count;
    logic [2:0]  pixel_bytes;
    logic        msb_first;
    logic [7:0]  data;
    logic [31:0] fore;
    logic [31:0] back;
  } job_t;

  // bytes per pixel clamped into 1..4
  function automatic logic [2:0] clamp_bpp(input logic [2:0] bpp);
    logic [2:0] r;
    if (bpp == 3'd0) begin
      r = 3'd1;
    end else if (bpp > 3'd4) begin
      r = 3'd4;
    end else begin
      r = bpp;
    end
    return r;
  endfunction

  // one channel: top bits of the value, moved to the mask position
  function automatic logic [31:0] pack_channel(input logic [7:0] value,
                                               input logic [8:0] format);
    logic [3:0]  size;
    logic [4:0]  shift;
    logic [7:0]  kept;
    logic [39:0] wide;
    size = (format[8:5] > 4'd8) ? 4'd8 : format[8:5];
    shift = format[4:0];
    kept = value >> (4'd8 - size);
    wide = {32'd0, kept} << shift;
    return wide[31:0];
  endfunction

  function automatic logic [31:0] pack_colour(input logic [23:0] rgb,
                                              input cfg_t cfg);
    return pack_channel(rgb[23:16], cfg.red_format)
         | pack_channel(rgb[15:8], cfg.green_format)
         | pack_channel(rgb[7:0], cfg.blue_format);
  endfunction

endpackage
`default_nettype wire

@@ sv/mono_bitmap_color_expand_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mono_bitmap_color_expand_top
// Monochrome bitmap colour expansion into framebuffer pixel writes.
// ----------------------------------------------------------------------------
// A start request clips the bitmap against the screen and packs both colours;
// each following data byte becomes up to eight pixel writes. Requests are
// taken one per cycle while the two-entry job queue has room, including
// while a result waits to be popped. Writes leave one per cycle from the
// address stepper in the back end while the result register is free or
// being popped, one per visible pixel of a byte, and a start or a byte
// with no visible pixel yields no write. A data request passes through the
// job queue, the back end's job registers and the result register.
// ----------------------------------------------------------------------------
module mono_bitmap_color_expand_top (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  output logic                full,
  input  mbce_pkg::item_t     item,
  output logic                empty,
  input  wire                 pop,
  output mbce_pkg::result_t   result,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [2:0]           cfg_index,
  input  wire [31:0]          cfg_data
);
  import mbce_pkg::*;

  cfg_t    cfg;
  logic    accept;
  logic    job_push;
  job_t    front_job;
  logic    queue_full;
  logic    job_pop;
  logic    job_valid;
  job_t    head_job;
  logic    out_valid;

  // handshakes
  always_comb begin
    cfg_ready = 1'b1;
    full = queue_full;
    accept = push && !queue_full;
    empty = !out_valid;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_address <= 32'd0;
      cfg.screen_width <= 13'd1024;
      cfg.screen_height <= 13'd768;
      cfg.row_pitch <= 16'd4096;
      cfg.bytes_per_pixel <= 3'd4;
      cfg.red_format <= 9'd272;
      cfg.green_format <= 9'd264;
      cfg.blue_format <= 9'd256;
    end else if (cfg_valid) begin
      case (reg_index_t'(cfg_index))
        REG_BASE_ADDRESS:    cfg.base_address <= cfg_data;
        REG_SCREEN_WIDTH:    cfg.screen_width <= cfg_data[12:0];
        REG_SCREEN_HEIGHT:   cfg.screen_height <= cfg_data[12:0];
        REG_ROW_PITCH:       cfg.row_pitch <= cfg_data[15:0];
        REG_BYTES_PER_PIXEL: cfg.bytes_per_pixel <= cfg_data[2:0];
        REG_RED_FORMAT:      cfg.red_format <= cfg_data[8:0];
        REG_GREEN_FORMAT:    cfg.green_format <= cfg_data[8:0];
        REG_BLUE_FORMAT:     cfg.blue_format <= cfg_data[8:0];
        default: begin
        end
      endcase
    end
  end

  // request decode and draw state
  mbce_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .cfg      (cfg),
    .job_push (job_push),
    .job      (front_job)
  );

  // job queue
  mbce_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (front_job),
    .full     (queue_full),
    .rd_en    (job_pop),
    .rd_valid (job_valid),
    .rd_job   (head_job)
  );

  // pixel write expansion
  mbce_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .job_valid  (job_valid),
    .job        (head_job),
    .job_pop    (job_pop),
    .out_valid  (out_valid),
    .out_pop    (pop),
    .out_result (result)
  );

endmodule
`default_nettype wire

@@ sv/mbce_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbce_queue
// Two-entry register queue of pixel jobs between the front and the back.
// ----------------------------------------------------------------------------
module mbce_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              wr_en,
  input  mbce_pkg::job_t   wr_job,
  output logic             full,
  input  wire              rd_en,
  output logic             rd_valid,
  output mbce_pkg::job_t   rd_job
);
  import mbce_pkg::*;

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  // status and head of queue
  always_comb begin
    full = (fill == 2'd2);
    rd_valid = (fill != 2'd0);
    rd_job = slots[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 2'd1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/mbce_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbce_front
// Takes requests: a start clips the bitmap and packs the colours, a data
// byte steps the bitmap position and queues a job for its visible pixels.
// ----------------------------------------------------------------------------
module mbce_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              accept,
  input  mbce_pkg::item_t  item,
  input  mbce_pkg::cfg_t   cfg,
  output logic             job_push,
  output mbce_pkg::job_t   job
);
  import mbce_pkg::*;

  logic        drawing;
  logic [11:0] origin_x;
  logic [12:0] row_abs;
  logic [12:0] col_abs;
  logic [12:0] clipped_width;
  logic [12:0] clipped_height;
  logic [12:0] full_height;
  logic [9:0]  stride_bytes;
  logic        bit_order;
  logic [31:0] fore_packed;
  logic [31:0] back_packed;
  logic [9:0]  byte_column;
  logic [12:0] bitmap_row;

  logic        is_data;
  logic        off_screen;
  logic [12:0] width_sat;
  logic [12:0] height_sat;
  logic [12:0] room_x;
  logic [12:0] room_y;
  logic [12:0] first_x;
  logic [12:0] remain_x;
  logic        row_visible;
  logic        col_visible;
  logic [3:0]  pixel_count;
  logic [10:0] column_inc;
  logic        row_end;
  logic [12:0] row_inc;
  logic [2:0]  bpp;
  logic [28:0] row_product;
  logic [15:0] col_product;

  // start geometry: off-screen test, saturation and clipping
  always_comb begin
    is_data = (item.operation == OP_DATA);
    off_screen = ({1'b0, item.dest_x} >= cfg.screen_width)
              || ({1'b0, item.dest_y} >= cfg.screen_height);
    width_sat = (item.glyph_width > MAX_DIM) ? MAX_DIM : item.glyph_width;
    height_sat = (item.glyph_height > MAX_DIM) ? MAX_DIM : item.glyph_height;
    room_x = cfg.screen_width - {1'b0, item.dest_x};
    room_y = cfg.screen_height - {1'b0, item.dest_y};
  end

  // data byte: visible pixel count and position stepping
  always_comb begin
    first_x = {byte_column, 3'b000};
    remain_x = clipped_width - first_x;
    row_visible = (bitmap_row < clipped_height);
    col_visible = (first_x < clipped_width);
    pixel_count = (remain_x >= 13'd8) ? 4'd8 : remain_x[3:0];
    column_inc = {1'b0, byte_column} + 11'd1;
    row_end = (column_inc >= {1'b0, stride_bytes});
    row_inc = bitmap_row + 13'd1;
  end

  // job for the back: address parts and colours
  always_comb begin
    bpp = clamp_bpp(cfg.bytes_per_pixel);
    row_product = 29'(row_abs * cfg.row_pitch);
    col_product = 16'(col_abs * bpp);
    job_push = accept && is_data && drawing && row_visible && col_visible;
    job.row_part = row_product;
    job.col_part = col_product;
    job.count = pixel_count;
    job.pixel_bytes = bpp;
    job.msb_first = bit_order;
    job.data = item.bitmap_byte;
    job.fore = fore_packed;
    job.back = back_packed;
  end

  // draw state
  always_ff @(posedge clk) begin
    if (rst) begin
      drawing <= 1'b0;
      origin_x <= 12'd0;
      row_abs <= 13'd0;
      col_abs <= 13'd0;
      clipped_width <= 13'd0;
      clipped_height <= 13'd0;
      full_height <= 13'd0;
      stride_bytes <= 10'd1;
      bit_order <= 1'b0;
      fore_packed <= 32'd0;
      back_packed <= 32'd0;
      byte_column <= 10'd0;
      bitmap_row <= 13'd0;
    end else if (accept) begin
      if (!is_data) begin
        if (off_screen) begin
          drawing <= 1'b0;
        end else begin
          drawing <= (item.glyph_height != 13'd0);
          origin_x <= item.dest_x;
          row_abs <= {1'b0, item.dest_y};
          col_abs <= {1'b0, item.dest_x};
          clipped_width <= (room_x < width_sat) ? room_x : width_sat;
          clipped_height <= (room_y < height_sat) ? room_y : height_sat;
          full_height <= height_sat;
          stride_bytes <= (item.glyph_stride == 10'd0) ? 10'd1 : item.glyph_stride;
          bit_order <= item.msb_first;
          fore_packed <= pack_colour(item.fore_rgb, cfg);
          back_packed <= pack_colour(item.back_rgb, cfg);
          byte_column <= 10'd0;
          bitmap_row <= 13'd0;
        end
      end else if (drawing) begin
        if (row_end) begin
          byte_column <= 10'd0;
          bitmap_row <= row_inc;
          row_abs <= row_abs + 13'd1;
          col_abs <= {1'b0, origin_x};
          if (row_inc >= full_height) begin
            drawing <= 1'b0;
          end
        end else begin
          byte_column <= column_inc[9:0];
          col_abs <= col_abs + 13'd8;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ sv/mbce_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbce_back
// Expands one queued job into a single result register, one pixel write a
// cycle unless a held result is not popped, stepping the address by pixel size.
// ----------------------------------------------------------------------------
module mbce_back (
  input  wire              clk,
  input  wire              rst,
  input  mbce_pkg::cfg_t   cfg,
  input  wire              job_valid,
  input  mbce_pkg::job_t   job,
  output logic             job_pop,
  output logic             out_valid,
  input  wire              out_pop,
  output mbce_pkg::result_t out_result
);
  import mbce_pkg::*;

  logic        active;
  logic [31:0] address;
  logic [2:0]  pixel;
  logic [3:0]  count;
  logic [2:0]  pixel_bytes;
  logic        msb_first;
  logic [7:0]  data;
  logic [31:0] fore;
  logic [31:0] back;

  logic        emit;
  logic        finish;
  logic        load;
  logic [2:0]  bit_sel;
  logic [31:0] colour;

  // stepping control
  always_comb begin
    emit = active && (!out_valid || out_pop);
    finish = emit && ({1'b0, pixel} == (count - 4'd1));
    load = job_valid && (!active || finish);
    job_pop = load;
    bit_sel = msb_first ? (3'd7 - pixel) : pixel;
    colour = data[bit_sel] ? fore : back;
  end

  // current job and address stepper
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
    end else if (finish) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      address <= cfg.base_address + {3'd0, job.row_part} + {16'd0, job.col_part};
      pixel <= 3'd0;
      count <= job.count;
      pixel_bytes <= job.pixel_bytes;
      msb_first <= job.msb_first;
      data <= job.data;
      fore <= job.fore;
      back <= job.back;
    end else if (emit) begin
      address <= address + {29'd0, pixel_bytes};
      pixel <= pixel + 3'd1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_result.write_address <= address;
      out_result.pixel_value <= colour;
      out_result.byte_count <= pixel_bytes;
      out_result.last <= finish;
    end
  end

endmodule
`default_nettype wire

@@ tb/mbce_write_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_write_checker
// Predicts and checks the pixel writes of the colour expansion blitter.
// ----------------------------------------------------------------------------
// Watches the request, result and register channels. Register writes update a
// local copy of the configuration, and every accepted request runs through a
// behavioural model of the blitter that queues the pixel writes it yields.
// Each popped result is compared field by field against the oldest queued
// write. The error count and the number of writes still owed go to the top.
// ----------------------------------------------------------------------------
module mbce_write_checker (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  wire                full,
  input  mbce_pkg::item_t    item,
  input  wire                empty,
  input  wire                pop,
  input  mbce_pkg::result_t  result,
  input  wire                cfg_valid,
  input  wire                cfg_ready,
  input  wire [2:0]          cfg_index,
  input  wire [31:0]         cfg_data,
  output int                 errors,
  output int                 pending
);
  import mbce_pkg::*;

  // local copy of the register file
  cfg_t regs;

  // draw state latched by a start request
  logic        drawing;
  logic        msb_left;
  int unsigned org_x, org_y;
  int unsigned clip_w, clip_h, rows_total, stride;
  int unsigned col, row;
  logic [31:0] fore_px, back_px;

  // pixel writes owed by the block, oldest first
  result_t queued_writes[$];

  // top bits of one channel moved to their mask position, kept to 32 bits
  function automatic logic [31:0] place_channel(input logic [7:0] value,
                                                input logic [8:0] fmt);
    int unsigned bits;
    logic [63:0] field;
    bits = (fmt[8:5] > 4'd8) ? 8 : fmt[8:5];
    field = 64'(value >> (8 - bits));
    field = field << fmt[4:0];
    return field[31:0];
  endfunction

  function automatic logic [31:0] pack_rgb(input logic [23:0] rgb);
    return place_channel(rgb[23:16], regs.red_format)
         | place_channel(rgb[15:8], regs.green_format)
         | place_channel(rgb[7:0], regs.blue_format);
  endfunction

  // start request: clip against the screen, or drop the draw when off screen
  task automatic latch_draw(input item_t it);
    int unsigned gw, gh;
    drawing = 1'b0;
    if (it.dest_x < regs.screen_width && it.dest_y < regs.screen_height) begin
      gw = (it.glyph_width > MAX_DIM) ? MAX_DIM : it.glyph_width;
      gh = (it.glyph_height > MAX_DIM) ? MAX_DIM : it.glyph_height;
      org_x = it.dest_x;
      org_y = it.dest_y;
      clip_w = (regs.screen_width - it.dest_x < gw) ? regs.screen_width - it.dest_x : gw;
      clip_h = (regs.screen_height - it.dest_y < gh) ? regs.screen_height - it.dest_y : gh;
      rows_total = gh;
      stride = (it.glyph_stride == 10'd0) ? 1 : it.glyph_stride;
      msb_left = it.msb_first;
      fore_px = pack_rgb(it.fore_rgb);
      back_px = pack_rgb(it.back_rgb);
      col = 0;
      row = 0;
      drawing = (gh != 0);
    end
  endtask

  // data request: one write per visible bit, geometry read as it stands now
  task automatic expand_byte(input logic [7:0] bits);
    int unsigned bpp, x, sel, n, b, i;
    result_t burst [8];
    if (drawing) begin
      if (regs.bytes_per_pixel == 3'd0) begin
        bpp = 1;
      end else if (regs.bytes_per_pixel > 3'd4) begin
        bpp = 4;
      end else begin
        bpp = regs.bytes_per_pixel;
      end
      n = 0;
      if (row < clip_h) begin
        for (b = 0; b < 8; b++) begin
          x = col * 8 + b;
          if (x < clip_w) begin
            sel = msb_left ? 7 - b : b;
            burst[n].write_address = regs.base_address
                                   + (org_y + row) * regs.row_pitch
                                   + (org_x + x) * bpp;
            burst[n].pixel_value = bits[sel] ? fore_px : back_px;
            burst[n].byte_count = 3'(bpp);
            burst[n].last = 1'b0;
            n++;
          end
        end
        if (n > 0) begin
          burst[n - 1].last = 1'b1;
        end
        for (i = 0; i < n; i++) begin
          queued_writes.push_back(burst[i]);
        end
      end
      // step through the bitmap, closing the draw after its last row
      col++;
      if (col >= stride) begin
        col = 0;
        row++;
        if (row >= rows_total) begin
          drawing = 1'b0;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // sample all three channels at the rising edge
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      regs.base_address = 32'd0;
      regs.screen_width = 13'd1024;
      regs.screen_height = 13'd768;
      regs.row_pitch = 16'd4096;
      regs.bytes_per_pixel = 3'd4;
      regs.red_format = 9'd272;
      regs.green_format = 9'd264;
      regs.blue_format = 9'd256;
      drawing = 1'b0;
      msb_left = 1'b0;
      org_x = 0;
      org_y = 0;
      clip_w = 0;
      clip_h = 0;
      rows_total = 0;
      stride = 1;
      col = 0;
      row = 0;
      fore_px = 32'd0;
      back_px = 32'd0;
      queued_writes.delete();
    end else begin
      // popped write against the oldest one owed
      if (pop && !empty) begin
        if (queued_writes.size() == 0) begin
          errors++;
          $display("%0t: unexpected write, expected none, actual addr %h value %h",
                   $time, result.write_address, result.pixel_value);
        end else begin
          want = queued_writes.pop_front();
          check_field("write_address", want.write_address, result.write_address);
          check_field("pixel_value", want.pixel_value, result.pixel_value);
          check_field("byte_count", 32'(want.byte_count), 32'(result.byte_count));
          check_field("last", 32'(want.last), 32'(result.last));
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_ADDRESS:    regs.base_address = cfg_data;
          REG_SCREEN_WIDTH:    regs.screen_width = cfg_data[12:0];
          REG_SCREEN_HEIGHT:   regs.screen_height = cfg_data[12:0];
          REG_ROW_PITCH:       regs.row_pitch = cfg_data[15:0];
          REG_BYTES_PER_PIXEL: regs.bytes_per_pixel = cfg_data[2:0];
          REG_RED_FORMAT:      regs.red_format = cfg_data[8:0];
          REG_GREEN_FORMAT:    regs.green_format = cfg_data[8:0];
          REG_BLUE_FORMAT:     regs.blue_format = cfg_data[8:0];
          default: ;
        endcase
      end
      // accepted request
      if (push && !full) begin
        if (item.operation == OP_START) begin
          latch_draw(item);
        end else begin
          expand_byte(item.bitmap_byte);
        end
      end
    end
    pending = queued_writes.size();
  end

endmodule

@@ tb/tb_mono_bitmap_color_expand_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mono_bitmap_color_expand_top
// Stimulus and verdict for the monochrome colour expansion blitter.
// ----------------------------------------------------------------------------
// Drives a directed set of draws covering clipping, discarded and zero-height
// starts, saturated sizes, zero stride, aborted draws and stray bytes, then
// random draws across several register settings, extremes included. Register
// writes happen only once the block has drained. Both the request side and
// the result side stall at random, with one stretch that runs flat out.
// Checking is done by the write checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_mono_bitmap_color_expand_top;
  import mbce_pkg::*;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  item_t       item;
  logic        empty;
  logic        pop;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;

  // stimulus shaping state
  logic        steady;
  int unsigned scr_w, scr_h;
  int unsigned bytes_left;
  int unsigned sent;
  int unsigned phase;

  mono_bitmap_color_expand_top dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbce_write_checker write_check (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side: pop with random stalls
  initial begin
    pop = 1'b0;
    forever begin
      @(negedge clk);
      pop = steady || ($urandom_range(99) >= 18);
    end
  end

  function automatic item_t random_item();
    item_t it;
    it.operation = 1'($urandom_range(1));
    it.dest_x = 12'($urandom);
    it.dest_y = 12'($urandom);
    it.glyph_width = 13'($urandom);
    it.glyph_height = 13'($urandom);
    it.glyph_stride = 10'($urandom);
    it.msb_first = 1'($urandom_range(1));
    it.fore_rgb = 24'($urandom);
    it.back_rgb = 24'($urandom);
    it.bitmap_byte = 8'($urandom);
    return it;
  endfunction

  function automatic item_t start_item(input int unsigned dx, dy, w, h, s,
                                       input logic msb, input logic [23:0] fore, back);
    item_t it;
    it = random_item();
    it.operation = OP_START;
    it.dest_x = 12'(dx);
    it.dest_y = 12'(dy);
    it.glyph_width = 13'(w);
    it.glyph_height = 13'(h);
    it.glyph_stride = 10'(s);
    it.msb_first = msb;
    it.fore_rgb = fore;
    it.back_rgb = back;
    return it;
  endfunction

  function automatic item_t data_item(input logic [7:0] bits);
    item_t it;
    it = random_item();
    it.operation = OP_DATA;
    it.bitmap_byte = bits;
    return it;
  endfunction

  function automatic logic [31:0] one_of(input logic [31:0] lo, hi, mid);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return mid;
    endcase
  endfunction

  // one request, with random idle cycles ahead of it
  task automatic send(input item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 18) begin
      push = 1'b0;
      @(negedge clk);
    end
    push = 1'b1;
    item = it;
    do begin
      @(posedge clk);
    end while (full);
    sent++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (idx == REG_SCREEN_WIDTH) begin
      scr_w = val[12:0];
    end
    if (idx == REG_SCREEN_HEIGHT) begin
      scr_h = val[12:0];
    end
  endtask

  // hold requests until every write has come out, then let the pipe empty
  task automatic settle();
    @(negedge clk);
    push = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // new register setting, extremes favoured
  task automatic reconfigure(input bit every);
    if (every || $urandom_range(9) < 6) begin
      write_reg(REG_BASE_ADDRESS, one_of(32'd0, 32'hFFFF_FFFF, $urandom));
    end
    if (every || $urandom_range(9) < 6) begin
      write_reg(REG_SCREEN_WIDTH, ($urandom_range(9) == 0) ? $urandom_range(8191)
                : one_of(32'd1, 32'd4096, $urandom_range(1, 4096)));
    end
    if (every || $urandom_range(9) < 6) begin
      write_reg(REG_SCREEN_HEIGHT, ($urandom_range(9) == 0) ? $urandom_range(8191)
                : one_of(32'd1, 32'd4096, $urandom_range(1, 4096)));
    end
    if (every || $urandom_range(9) < 6) begin
      write_reg(REG_ROW_PITCH, one_of(32'd1, 32'd65535, $urandom_range(65535)));
    end
    if (every || $urandom_range(9) < 6) begin
      write_reg(REG_BYTES_PER_PIXEL, $urandom_range(7));
    end
    if (every || $urandom_range(9) < 6) begin
      case ($urandom_range(2))
        // 8:8:8 layout
        0: begin
          write_reg(REG_RED_FORMAT, 32'd272);
          write_reg(REG_GREEN_FORMAT, 32'd264);
          write_reg(REG_BLUE_FORMAT, 32'd256);
        end
        // 5:6:5 layout
        1: begin
          write_reg(REG_RED_FORMAT, 32'd171);
          write_reg(REG_GREEN_FORMAT, 32'd197);
          write_reg(REG_BLUE_FORMAT, 32'd160);
        end
        default: begin
          write_reg(REG_RED_FORMAT, one_of(32'd0, 32'd511, $urandom_range(511)));
          write_reg(REG_GREEN_FORMAT, one_of(32'd0, 32'd287, $urandom_range(511)));
          write_reg(REG_BLUE_FORMAT, one_of(32'd0, 32'd511, $urandom_range(511)));
        end
      endcase
    end
  endtask

  // next request of the random stream: mostly complete draws, some noise
  task automatic stream_step();
    item_t       it;
    int unsigned xmax, ymax, s, eff, rows;
    if (bytes_left > 0 && $urandom_range(99) < 92) begin
      send(data_item(8'($urandom)));
      bytes_left--;
    end else if ($urandom_range(99) < 80) begin
      it = start_item(0, 0, 0, 0, 0, 1'($urandom_range(1)), 24'($urandom), 24'($urandom));
      xmax = (scr_w > 4096) ? 4096 : scr_w;
      ymax = (scr_h > 4096) ? 4096 : scr_h;
      // destination on screen, often hard against the right or bottom edge
      if (xmax > 0) begin
        it.dest_x = ($urandom_range(3) == 0)
                  ? 12'(xmax - 1 - $urandom_range(0, (xmax > 8) ? 7 : xmax - 1))
                  : 12'($urandom_range(0, xmax - 1));
      end
      if (ymax > 0) begin
        it.dest_y = ($urandom_range(3) == 0)
                  ? 12'(ymax - 1 - $urandom_range(0, (ymax > 4) ? 3 : ymax - 1))
                  : 12'($urandom_range(0, ymax - 1));
      end
      case ($urandom_range(19))
        0: s = 0;
        1: s = $urandom_range(4, 1023);
        default: s = $urandom_range(1, 3);
      endcase
      eff = (s == 0) ? 1 : s;
      it.glyph_stride = 10'(s);
      it.glyph_width = ($urandom_range(19) == 0) ? 13'($urandom)
                     : 13'($urandom_range(0, ((eff > 4) ? 4 : eff) * 8 + 4));
      rows = ($urandom_range(19) == 0) ? $urandom_range(4096, 8191) : $urandom_range(1, 4);
      it.glyph_height = 13'(rows);
      // long draws are cut short by the next start
      bytes_left = (rows * eff > 24) ? 24 : rows * eff;
      send(it);
    end else begin
      send(random_item());
    end
  endtask

  initial begin
    rst = 1'b1;
    push = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = 3'd0;
    cfg_data = 32'd0;
    steady = 1'b0;
    scr_w = 1024;
    scr_h = 768;
    bytes_left = 0;
    sent = 0;
    phase = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // 32-bit pixels on a 1024 x 768 screen
    write_reg(REG_BASE_ADDRESS, 32'h1000_0000);
    write_reg(REG_SCREEN_WIDTH, 32'd1024);
    write_reg(REG_SCREEN_HEIGHT, 32'd768);
    write_reg(REG_ROW_PITCH, 32'd4096);
    write_reg(REG_BYTES_PER_PIXEL, 32'd4);
    write_reg(REG_RED_FORMAT, 32'd272);
    write_reg(REG_GREEN_FORMAT, 32'd264);
    write_reg(REG_BLUE_FORMAT, 32'd256);

    // stray byte with no draw open
    send(data_item(8'hFF));
    // plain two-row draw, msb first, then a byte after it closed
    send(start_item(0, 0, 8, 2, 1, 1'b1, 24'hFFFFFF, 24'h000000));
    send(data_item(8'hA5));
    send(data_item(8'h00));
    send(data_item(8'hFF));
    // destination off the right, then off the bottom
    send(start_item(4095, 10, 8, 1, 1, 1'b0, 24'h112233, 24'h445566));
    send(data_item(8'h5A));
    send(start_item(10, 4095, 8, 1, 1, 1'b0, 24'h112233, 24'h445566));
    // zero height
    send(start_item(3, 3, 8, 0, 1, 1'b0, 24'h112233, 24'h445566));
    send(data_item(8'hFF));
    // saturated size and zero stride, clipped at the bottom right corner
    send(start_item(1020, 766, 8191, 8191, 0, 1'b0, 24'h00FF00, 24'hFF00FF));
    send(data_item(8'h0F));
    send(data_item(8'hF0));
    send(data_item(8'hFF));
    // width past the stride is never drawn, then a new start
    send(start_item(10, 5, 20, 1, 2, 1'b0, 24'h123456, 24'hABCDEF));
    send(data_item(8'h3C));
    send(data_item(8'hC3));
    send(start_item(100, 200, 3, 2, 1, 1'b1, 24'h808080, 24'h7F7F7F));
    send(data_item(8'h80));
    send(data_item(8'h01));
    settle();

    // extreme setting: wrapping base, widest pitch, odd pixel size and masks
    write_reg(REG_BASE_ADDRESS, 32'hFFFF_FFF0);
    write_reg(REG_SCREEN_WIDTH, 32'd4096);
    write_reg(REG_SCREEN_HEIGHT, 32'd4096);
    write_reg(REG_ROW_PITCH, 32'd65535);
    write_reg(REG_BYTES_PER_PIXEL, 32'd0);
    write_reg(REG_RED_FORMAT, 32'd511);
    write_reg(REG_GREEN_FORMAT, 32'd287);
    write_reg(REG_BLUE_FORMAT, 32'd0);
    send(start_item(4095, 4095, 4096, 4096, 1023, 1'b1, 24'hFFFFFF, 24'h000000));
    send(data_item(8'h80));
    send(data_item(8'h7F));

    // random draws across changing settings; a draw may span a setting change
    while (sent < 250) begin
      settle();
      reconfigure(phase == 0);
      steady = (phase == 2);
      repeat (40) stream_step();
      phase++;
    end
    steady = 1'b0;
    settle();

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
